[hw/rtl/lcs_pkg.sv]
// lcs_pkg: shared types and constants for the lru cache set block
// covers command codes, per-way state layout and result layout
// no dependencies
package lcs_pkg;

    localparam int MAX_WAYS       = 8;
    localparam int TAG_BITS       = 32;
    localparam int WAY_BITS       = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int CNT_BITS       = $clog2(MAX_WAYS + 1);
    localparam int CFG_BITS       = 4;
    localparam int CFG_RESET      = 8;
    localparam int APB_ADDR_BITS  = 3;
    localparam int APB_DATA_BITS  = 32;
    localparam int CMD_BITS       = 2;
    localparam int IN_TDATA_BITS  = 40;
    localparam int OUT_TDATA_BITS = 40;

    localparam logic REG_WAYS_IN_USE = 1'b0;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_PROBE = 2'd2,
        CMD_INVAL = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [MAX_WAYS-1:0][TAG_BITS-1:0] tags;
        logic [MAX_WAYS-1:0]               valid;
        logic [MAX_WAYS-1:0]               dirty;
        logic [MAX_WAYS-1:0][WAY_BITS-1:0] rec;
    } t_set_state;

    typedef struct packed {
        logic                hit;
        logic                evicted;
        logic [TAG_BITS-1:0] victim_tag;
        logic                victim_dirty;
    } t_result;

endpackage

[hw/rtl/lcs_cfg_regs.sv]
// lcs_cfg_regs: apb register for the associativity setting
// holds ways_in_use and hands the clamped way limit to the access logic
// depends on lcs_pkg
module lcs_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lcs_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [lcs_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [lcs_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                pready,
    output logic [lcs_pkg::CNT_BITS-1:0]        o_way_limit
);
    import lcs_pkg::*;

    logic [CFG_BITS-1:0] r_ways_in_use;
    logic                wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready
                    && (paddr[APB_ADDR_BITS-1] == REG_WAYS_IN_USE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ways_in_use <= CFG_BITS'(CFG_RESET);
        end else if (wr_en) begin
            r_ways_in_use <= pwdata[CFG_BITS-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[APB_ADDR_BITS-1] == REG_WAYS_IN_USE) begin
            prdata[CFG_BITS-1:0] = r_ways_in_use;
        end
    end

    // zero acts as one, anything above the way count acts as the way count
    always_comb begin
        if (r_ways_in_use == '0) begin
            o_way_limit = CNT_BITS'(1);
        end else if (32'(r_ways_in_use) > MAX_WAYS) begin
            o_way_limit = CNT_BITS'(MAX_WAYS);
        end else begin
            o_way_limit = CNT_BITS'(r_ways_in_use);
        end
    end

endmodule

[hw/rtl/lcs_access.sv]
// lcs_access: single-pass lookup and true lru update for one request
// compares all ways in parallel, picks victim or free way, builds next state
// depends on lcs_pkg
module lcs_access (
    input  lcs_pkg::t_set_state             i_state,
    input  lcs_pkg::t_cmd                   i_cmd,
    input  logic [lcs_pkg::TAG_BITS-1:0]    i_tag,
    input  logic [lcs_pkg::CNT_BITS-1:0]    i_way_limit,
    output lcs_pkg::t_set_state             o_state,
    output lcs_pkg::t_result                o_result
);
    import lcs_pkg::*;

    logic [MAX_WAYS-1:0] hit_vec;
    logic [WAY_BITS-1:0] hit_way;
    logic [WAY_BITS-1:0] hit_rank;
    logic [CNT_BITS-1:0] valid_cnt;
    logic [WAY_BITS-1:0] lru_way;
    logic [WAY_BITS-1:0] lru_rank;
    logic                lru_found;
    logic [WAY_BITS-1:0] free_way;
    logic [WAY_BITS-1:0] fill_way;
    logic                is_full;

    always_comb begin
        hit_vec   = '0;
        hit_way   = '0;
        free_way  = '0;
        valid_cnt = '0;
        for (int i = MAX_WAYS - 1; i >= 0; i--) begin
            hit_vec[i] = i_state.valid[i] && (i_state.tags[i] == i_tag);
            if (hit_vec[i]) begin
                hit_way = WAY_BITS'(i);
            end
            if (!i_state.valid[i]) begin
                free_way = WAY_BITS'(i);
            end
        end
        for (int i = 0; i < MAX_WAYS; i++) begin
            valid_cnt = valid_cnt + CNT_BITS'(i_state.valid[i]);
        end
        hit_rank = i_state.rec[hit_way];
    end

    // least recent valid way, lowest index on a tie
    always_comb begin
        lru_way   = '0;
        lru_rank  = '0;
        lru_found = 1'b0;
        for (int i = 0; i < MAX_WAYS; i++) begin
            if (i_state.valid[i] && (!lru_found || i_state.rec[i] > lru_rank)) begin
                lru_way   = WAY_BITS'(i);
                lru_rank  = i_state.rec[i];
                lru_found = 1'b1;
            end
        end
    end

    assign is_full = (valid_cnt >= i_way_limit);

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        fill_way = free_way;
        o_result.hit = |hit_vec;
        unique case (i_cmd)
            CMD_READ, CMD_WRITE: begin
                if (|hit_vec) begin
                    for (int i = 0; i < MAX_WAYS; i++) begin
                        if (i_state.valid[i] && i_state.rec[i] < hit_rank) begin
                            o_state.rec[i] = i_state.rec[i] + WAY_BITS'(1);
                        end
                    end
                    o_state.rec[hit_way] = '0;
                    if (i_cmd == CMD_WRITE) begin
                        o_state.dirty[hit_way] = 1'b1;
                    end
                end else begin
                    if (is_full) begin
                        o_result.evicted      = 1'b1;
                        o_result.victim_tag   = i_state.tags[lru_way];
                        o_result.victim_dirty = i_state.dirty[lru_way];
                        o_state.valid[lru_way] = 1'b0;
                        fill_way = lru_way;
                    end
                    for (int i = 0; i < MAX_WAYS; i++) begin
                        if (o_state.valid[i]) begin
                            o_state.rec[i] = i_state.rec[i] + WAY_BITS'(1);
                        end
                    end
                    o_state.tags[fill_way]  = i_tag;
                    o_state.valid[fill_way] = 1'b1;
                    o_state.dirty[fill_way] = (i_cmd == CMD_WRITE);
                    o_state.rec[fill_way]   = '0;
                end
            end
            CMD_PROBE: begin
            end
            CMD_INVAL: begin
                if (|hit_vec) begin
                    o_state.valid[hit_way] = 1'b0;
                    o_state.dirty[hit_way] = 1'b0;
                    o_state.rec[hit_way]   = '0;
                    for (int i = 0; i < MAX_WAYS; i++) begin
                        if (o_state.valid[i] && i_state.rec[i] > hit_rank) begin
                            o_state.rec[i] = i_state.rec[i] - WAY_BITS'(1);
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

endmodule

[hw/rtl/lru_cache_set.sv]
// One set of a set-associative cache with true LRU replacement and write-back
// dirty marks. Each stream request (command, tag) gives exactly one result
// (hit, evicted, victim tag, victim dirty). A request passes an input register,
// parallel tag compare and LRU update logic, and a result register; one request is
// taken every cycle while results are drained, and the compare-and-update logic
// between the two registers sets that rate. Reset empties the set and loads
// ways_in_use with 8. The user must write ways_in_use over APB at address 0 only
// while no request is in flight; the block itself does not enforce this.
//
// depends on lcs_pkg, lcs_cfg_regs, lcs_access
module lru_cache_set (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // command [1:0], tag [33:2], zero fill above
    input  logic [lcs_pkg::IN_TDATA_BITS-1:0]       s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // hit [0], evicted [1], victim_tag [33:2], victim_dirty [34], zero fill above
    output logic [lcs_pkg::OUT_TDATA_BITS-1:0]      m_axis_tdata,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [lcs_pkg::APB_ADDR_BITS-1:0]       paddr,
    input  logic [lcs_pkg::APB_DATA_BITS-1:0]       pwdata,
    output logic [lcs_pkg::APB_DATA_BITS-1:0]       prdata,
    output logic                                    pready
);
    import lcs_pkg::*;

    logic                r_in_valid;
    t_cmd                r_in_cmd;
    logic [TAG_BITS-1:0] r_in_tag;
    logic                r_out_valid;
    t_result             r_out;
    t_set_state          r_state;
    t_set_state          n_state;
    t_result             n_result;
    logic [CNT_BITS-1:0] way_limit;
    logic                advance;
    logic                fire;

    lcs_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_way_limit (way_limit)
    );

    lcs_access u_access (
        .i_state     (r_state),
        .i_cmd       (r_in_cmd),
        .i_tag       (r_in_tag),
        .i_way_limit (way_limit),
        .o_state     (n_state),
        .o_result    (n_result)
    );

    assign advance       = !r_out_valid || m_axis_tready;
    assign fire          = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_cmd <= t_cmd'(s_axis_tdata[CMD_BITS-1:0]);
            r_in_tag <= s_axis_tdata[CMD_BITS +: TAG_BITS];
        end
    end

    // set state, tags hold no reset value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.valid <= '0;
            r_state.dirty <= '0;
            r_state.rec   <= '0;
        end else if (fire) begin
            r_state.valid <= n_state.valid;
            r_state.dirty <= n_state.dirty;
            r_state.rec   <= n_state.rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_state.tags <= n_state.tags;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= n_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OUT_TDATA_BITS - TAG_BITS - 3)'(0), r_out.victim_dirty,
                            r_out.victim_tag, r_out.evicted, r_out.hit};

    a_evict_not_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.hit && r_out.evicted))
        else $error("eviction reported on a hit");

    a_evict_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && n_result.evicted)
        |=> ($countones(r_state.valid) == $countones($past(r_state.valid))))
        else $error("eviction changed the number of valid ways");

    a_probe_no_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_in_cmd == CMD_PROBE)
        |=> ($stable(r_state.valid) && $stable(r_state.rec) && $stable(r_state.dirty)))
        else $error("probe changed the set state");

    a_evict_needs_miss_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && n_result.evicted) |-> (r_in_cmd == CMD_READ || r_in_cmd == CMD_WRITE))
        else $error("eviction on probe or invalidate");

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps
// tb: self-checking bench for lru_cache_set, one cache set with true lru and dirty marks
// drives access requests and apb register writes, checks each result against a local lru
// predictor or a directed expectation; depends on lcs_pkg and the lru_cache_set rtl
module tb;
    import lcs_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEMS_PER_CHUNK = 100;
    localparam logic [APB_ADDR_BITS-1:0] ADDR_WAYS_IN_USE = {REG_WAYS_IN_USE, 2'b00};

    typedef struct {
        bit                  is_cfg;
        t_cmd                cmd;
        logic [TAG_BITS-1:0] tag;
        bit                  typed;
        t_result             want;
    } t_row;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [IN_TDATA_BITS-1:0]  s_axis_tdata = '0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [OUT_TDATA_BITS-1:0] m_axis_tdata;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [APB_ADDR_BITS-1:0]  paddr = '0;
    logic [APB_DATA_BITS-1:0]  pwdata = '0;
    logic [APB_DATA_BITS-1:0]  prdata;
    logic                      pready;

    // predictor copy of the set
    logic [TAG_BITS-1:0] way_tag [MAX_WAYS];
    bit                  way_vld [MAX_WAYS];
    bit                  way_dirty [MAX_WAYS];
    int                  way_rank [MAX_WAYS];
    logic [CFG_BITS-1:0] shadow_ways;

    t_result             result_q [$];
    t_row                dir_rows [$];
    logic [TAG_BITS-1:0] tag_pool [$];
    int                  err_cnt = 0;
    int                  src_idle_pct = 0;
    int                  sink_idle_pct = 0;
    bit                  hold_arm = 1'b0;
    int                  hold_left = 0;
    int                  quiet_cycles = 0;

    lru_cache_set dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        err_cnt++;
    endtask

    function automatic t_result lru_access(t_cmd cmd, logic [TAG_BITS-1:0] tag);
        t_result res;
        int hit_way;
        int slot;
        int used;
        int lim;
        int rk;
        int oldest;
        res = '0;
        hit_way = -1;
        slot = -1;
        used = 0;
        oldest = 0;
        for (int i = 0; i < MAX_WAYS; i++) begin
            if (hit_way < 0 && way_vld[i] && way_tag[i] == tag) hit_way = i;
            if (way_vld[i]) used++;
        end
        lim = (shadow_ways < 1) ? 1 : (shadow_ways > MAX_WAYS) ? MAX_WAYS : int'(shadow_ways);
        if (cmd == CMD_READ || cmd == CMD_WRITE) begin
            if (hit_way >= 0) begin
                rk = way_rank[hit_way];
                for (int i = 0; i < MAX_WAYS; i++) begin
                    if (way_vld[i] && way_rank[i] < rk) way_rank[i]++;
                end
                way_rank[hit_way] = 0;
                if (cmd == CMD_WRITE) way_dirty[hit_way] = 1'b1;
            end else begin
                // full set: throw out the single least recent way
                if (used >= lim) begin
                    for (int i = 0; i < MAX_WAYS; i++) begin
                        if (way_vld[i] && (slot < 0 || way_rank[i] > oldest)) begin
                            slot = i;
                            oldest = way_rank[i];
                        end
                    end
                    if (slot >= 0) begin
                        res.evicted = 1'b1;
                        res.victim_tag = way_tag[slot];
                        res.victim_dirty = way_dirty[slot];
                        way_vld[slot] = 1'b0;
                    end
                end
                if (slot < 0) begin
                    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
                        if (!way_vld[i]) slot = i;
                    end
                end
                if (slot >= 0) begin
                    for (int i = 0; i < MAX_WAYS; i++) begin
                        if (way_vld[i]) way_rank[i]++;
                    end
                    way_tag[slot] = tag;
                    way_vld[slot] = 1'b1;
                    way_dirty[slot] = (cmd == CMD_WRITE);
                    way_rank[slot] = 0;
                end
            end
        end else if (cmd == CMD_INVAL && hit_way >= 0) begin
            rk = way_rank[hit_way];
            way_vld[hit_way] = 1'b0;
            way_dirty[hit_way] = 1'b0;
            way_rank[hit_way] = 0;
            for (int i = 0; i < MAX_WAYS; i++) begin
                if (way_vld[i] && way_rank[i] > rk) way_rank[i]--;
            end
        end
        res.hit = (hit_way >= 0);
        return res;
    endfunction

    task automatic send_req(t_cmd cmd, logic [TAG_BITS-1:0] tag, bit typed, t_result want);
        t_result pred;
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{(IN_TDATA_BITS - TAG_BITS - CMD_BITS){1'b0}}, tag, cmd};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pred = lru_access(cmd, tag);
        result_q.push_back(typed ? want : pred);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_BITS-1:0] val);
        logic [APB_DATA_BITS-1:0] rd;
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= ADDR_WAYS_IN_USE;
        pwdata <= APB_DATA_BITS'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        shadow_ways = val;
        // read back
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rd = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        if (rd !== APB_DATA_BITS'(val)) report_mismatch("ways_in_use readback", rd, 32'(val));
    endtask

    function automatic void add_req(t_cmd cmd, logic [TAG_BITS-1:0] tag);
        dir_rows.push_back('{1'b0, cmd, tag, 1'b0, '0});
    endfunction

    function automatic void add_checked(t_cmd cmd, logic [TAG_BITS-1:0] tag, logic hit,
                                        logic evicted, logic [TAG_BITS-1:0] vtag, logic vdirty);
        t_result want;
        want.hit = hit;
        want.evicted = evicted;
        want.victim_tag = vtag;
        want.victim_dirty = vdirty;
        dir_rows.push_back('{1'b0, cmd, tag, 1'b1, want});
    endfunction

    function automatic void add_cfg(logic [CFG_BITS-1:0] val);
        dir_rows.push_back('{1'b1, CMD_READ, TAG_BITS'(val), 1'b0, '0});
    endfunction

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (hold_arm) begin
            hold_arm = 1'b0;
            hold_left = 64;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (result_q.size() == 0) begin
                report_mismatch("result with no request waiting", m_axis_tdata[31:0], '0);
            end else begin
                want = result_q.pop_front();
                if (m_axis_tdata[0] !== want.hit)
                    report_mismatch("hit", 32'(m_axis_tdata[0]), 32'(want.hit));
                if (m_axis_tdata[1] !== want.evicted)
                    report_mismatch("evicted", 32'(m_axis_tdata[1]), 32'(want.evicted));
                if (m_axis_tdata[33:2] !== want.victim_tag)
                    report_mismatch("victim_tag", m_axis_tdata[33:2], want.victim_tag);
                if (m_axis_tdata[34] !== want.victim_dirty)
                    report_mismatch("victim_dirty", 32'(m_axis_tdata[34]), 32'(want.victim_dirty));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (psel && penable)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    initial begin
        int src_pct [3];
        int sink_pct [3];
        logic [CFG_BITS-1:0] ways_seq [5];
        logic [TAG_BITS-1:0] tag;
        t_cmd cmd;
        int roll;
        int chunk;

        src_pct = '{20, 88, 0};
        sink_pct = '{88, 20, 0};
        ways_seq = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd3};
        for (int i = 0; i < MAX_WAYS; i++) begin
            way_tag[i] = '0;
            way_vld[i] = 1'b0;
            way_dirty[i] = 1'b0;
            way_rank[i] = 0;
        end
        shadow_ways = CFG_RESET;

        // empty set, extremes of the tag, every command
        add_checked(CMD_PROBE, 32'h0000_0000, 0, 0, '0, 0);
        add_checked(CMD_INVAL, 32'hFFFF_FFFF, 0, 0, '0, 0);
        add_checked(CMD_READ,  32'h0000_0000, 0, 0, '0, 0);
        add_checked(CMD_WRITE, 32'hFFFF_FFFF, 0, 0, '0, 0);
        add_checked(CMD_WRITE, 32'h0000_0000, 1, 0, '0, 0);
        add_checked(CMD_PROBE, 32'hFFFF_FFFF, 1, 0, '0, 0);
        add_checked(CMD_INVAL, 32'h0000_0000, 1, 0, '0, 0);
        // direct mapped, dirty and clean victims
        add_cfg(4'd1);
        add_checked(CMD_READ,  32'h1234_5678, 0, 1, 32'hFFFF_FFFF, 1);
        add_checked(CMD_WRITE, 32'hA5A5_A5A5, 0, 1, 32'h1234_5678, 0);
        // zero associativity behaves as one way
        add_cfg(4'd0);
        add_checked(CMD_READ,  32'h5A5A_5A5A, 0, 1, 32'hA5A5_A5A5, 1);
        // oversized associativity behaves as eight ways
        add_cfg(4'd15);
        for (int i = 1; i < MAX_WAYS; i++) add_req(CMD_READ, TAG_BITS'(i));
        add_checked(CMD_READ,  32'h0000_0008, 0, 1, 32'h5A5A_5A5A, 0);
        // associativity lowered while the set is full
        add_cfg(4'd2);
        add_checked(CMD_READ,  32'h0000_0009, 0, 1, 32'h0000_0001, 0);
        add_checked(CMD_PROBE, 32'h0000_0001, 0, 0, '0, 0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        src_idle_pct = 20;
        sink_idle_pct = 50;
        foreach (dir_rows[r]) begin
            if (dir_rows[r].is_cfg) begin
                wait_idle();
                cfg_write(dir_rows[r].tag[CFG_BITS-1:0]);
            end else begin
                send_req(dir_rows[r].cmd, dir_rows[r].tag, dir_rows[r].typed, dir_rows[r].want);
            end
        end

        for (int p = 0; p < 3; p++) begin
            src_idle_pct = src_pct[p];
            sink_idle_pct = sink_pct[p];
            for (int c = 0; c < 5; c++) begin
                chunk = p * 5 + c;
                wait_idle();
                cfg_write(chunk < 5 ? ways_seq[chunk] : CFG_BITS'($urandom_range(15)));
                if (p == 2 && c == 0) hold_arm = 1'b1;
                // small tag working set so hits, refills and evictions all happen
                tag_pool.delete();
                repeat ($urandom_range(2, 12)) tag_pool.push_back($urandom);
                repeat (ITEMS_PER_CHUNK) begin
                    if ($urandom_range(99) < 85)
                        tag = tag_pool[$urandom_range(tag_pool.size() - 1)];
                    else
                        tag = $urandom;
                    roll = $urandom_range(99);
                    if (roll < 40) cmd = CMD_READ;
                    else if (roll < 70) cmd = CMD_WRITE;
                    else if (roll < 85) cmd = CMD_PROBE;
                    else cmd = CMD_INVAL;
                    send_req(cmd, tag, 1'b0, '0);
                end
            end
        end

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end
endmodule
